// ===== hw/rtl/lzss_window_decompressor_assert.svh =====
// Assertion macros shared by the decompressor RTL.
// Each file that includes this header must have clk and arst_n in scope.
`ifndef LZSS_WINDOW_DECOMPRESSOR_ASSERT_SVH
`define LZSS_WINDOW_DECOMPRESSOR_ASSERT_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define LZSSWD_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define LZSSWD_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== hw/rtl/lzsswd_pkg.sv =====
// Package for the LZSS window decompressor: types, codes and format constants.
// No dependencies; the controller, window and top level refer to it by scoped names.
`default_nettype none

package lzsswd_pkg;

	// Input kind codes.
	localparam logic KIND_DATA    = 1'b0;
	localparam logic KIND_RESTART = 1'b1;

	// Token format constants.
	localparam int unsigned OFFSET_W  = 12;
	localparam int unsigned LEN_W     = 5;
	localparam logic [7:0]  FLAG_MARK = 8'hFF;
	localparam logic [4:0]  MIN_LEN   = 5'd3;

	// Window contents and write pointer after reset or restart.
	localparam logic [7:0]  FILL_BYTE = 8'h20;
	localparam logic [11:0] START_PTR = 12'hFF0;

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_COPY
	} state_t;

	// Request from the token controller to the window datapath.
	typedef struct packed {
		logic                restart;
		logic                issue;
		logic                lit;
		logic [7:0]          lit_byte;
		logic [OFFSET_W-1:0] addr;
		logic                last;
	} cmd_t;

	// Status from the window datapath back to the controller.
	typedef struct packed {
		logic take;
		logic idle;
	} stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lzsswd_if.sv =====
// Valid/ready channel interfaces for compressed input and decoded output.
// Depends on nothing; used by the top level and its submodules.
`default_nettype none

interface lzsswd_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] in_byte;

	modport source (output valid, output kind, output in_byte, input ready);
	modport sink (input valid, input kind, input in_byte, output ready);
endinterface

interface lzsswd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;

	modport source (output valid, output out_byte, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lzsswd_ram.sv =====
// Generic single-clock RAM, one write port and one read port with registered read.
// No dependencies.
`default_nettype none

module lzsswd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port; the output holds its value while no read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/lzsswd_ctrl.sv =====
// Token controller: parses flag, literal and pair bytes and sequences pair copies.
// Depends on lzsswd_pkg, lzsswd_if and the assertion header.
`default_nettype none
`include "lzss_window_decompressor_assert.svh"

module lzsswd_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	lzsswd_in_if.sink         comp_ch,
	input  wire lzsswd_pkg::stat_t stat,
	output lzsswd_pkg::cmd_t  cmd
);

	lzsswd_pkg::state_t state_q, state_d;

	logic [15:0]                     flags_q;
	logic                            pend_q;
	logic [7:0]                      low_q;
	logic [lzsswd_pkg::OFFSET_W-1:0] pos_q;
	logic [lzsswd_pkg::LEN_W-1:0]    rem_q;

	logic acc;
	logic is_restart;
	logic is_flag;
	logic is_lit;
	logic is_pair1;
	logic is_pair2;
	logic copy_last;

	// A new request is taken only between copies and with the datapath drained.
	assign comp_ch.ready = (state_q == lzsswd_pkg::ST_IDLE) && stat.idle;
	assign acc           = comp_ch.valid && comp_ch.ready;

	// Classify the incoming byte against the current token state.
	assign is_restart = (comp_ch.kind == lzsswd_pkg::KIND_RESTART);
	assign is_flag    = !is_restart && !flags_q[8];
	assign is_lit     = !is_restart && flags_q[8] && flags_q[0];
	assign is_pair1   = !is_restart && flags_q[8] && !flags_q[0] && !pend_q;
	assign is_pair2   = !is_restart && flags_q[8] && !flags_q[0] && pend_q;
	assign copy_last  = (rem_q == lzsswd_pkg::LEN_W'(1));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			lzsswd_pkg::ST_IDLE: begin
				if (acc && is_pair2) begin
					state_d = lzsswd_pkg::ST_COPY;
				end
			end
			lzsswd_pkg::ST_COPY: begin
				if (stat.take && copy_last) begin
					state_d = lzsswd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lzsswd_pkg::ST_IDLE;
			end
		endcase
	end

	// Requests to the window datapath.
	always_comb begin
		cmd = '0;
		case (state_q)
			lzsswd_pkg::ST_IDLE: begin
				cmd.restart  = acc && is_restart;
				cmd.issue    = acc && is_lit;
				cmd.lit      = 1'b1;
				cmd.lit_byte = comp_ch.in_byte;
				cmd.last     = 1'b1;
			end
			lzsswd_pkg::ST_COPY: begin
				cmd.issue = stat.take;
				cmd.addr  = pos_q;
				cmd.last  = copy_last;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State register and token state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lzsswd_pkg::ST_IDLE;
			flags_q <= '0;
			pend_q  <= 1'b0;
			low_q   <= '0;
			pos_q   <= '0;
			rem_q   <= '0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				if (is_restart) begin
					flags_q <= '0;
					pend_q  <= 1'b0;
					low_q   <= '0;
				end else if (is_flag) begin
					flags_q <= {lzsswd_pkg::FLAG_MARK, comp_ch.in_byte};
				end else if (is_lit) begin
					flags_q <= flags_q >> 1;
				end else if (is_pair1) begin
					pend_q <= 1'b1;
					low_q  <= comp_ch.in_byte;
				end else begin
					// Second pair byte: latch offset and length, start the copy.
					pos_q   <= {comp_ch.in_byte[7:4], low_q};
					rem_q   <= {1'b0, comp_ch.in_byte[3:0]} + lzsswd_pkg::MIN_LEN;
					pend_q  <= 1'b0;
					low_q   <= '0;
					flags_q <= flags_q >> 1;
				end
			end else if ((state_q == lzsswd_pkg::ST_COPY) && stat.take) begin
				pos_q <= pos_q + lzsswd_pkg::OFFSET_W'(1);
				rem_q <= rem_q - lzsswd_pkg::LEN_W'(1);
			end
		end
	end

	`LZSSWD_ASSERT_NOW(a_copy_rem_nonzero, state_q == lzsswd_pkg::ST_COPY, rem_q != '0, "copy active with no bytes left")
	`LZSSWD_ASSERT_NOW(a_restart_when_idle, cmd.restart, stat.idle && !cmd.issue, "restart while datapath busy")
	`LZSSWD_ASSERT_NEXT(a_restart_clears, acc && is_restart, !pend_q && !flags_q[8] && state_q == lzsswd_pkg::ST_IDLE, "restart left token state")

endmodule

`default_nettype wire

// ===== hw/rtl/lzsswd_window.sv =====
// Window datapath: history RAM, write pointer, fill count, forwarding and output register.
// Depends on lzsswd_pkg, lzsswd_if, lzsswd_ram and the assertion header.
`default_nettype none
`include "lzss_window_decompressor_assert.svh"

module lzsswd_window #(
	parameter int unsigned WINDOW_SIZE = 4096
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lzsswd_pkg::cmd_t  cmd,
	output lzsswd_pkg::stat_t      stat,
	lzsswd_out_if.source           data_ch
);

	localparam int unsigned AW = $clog2(WINDOW_SIZE);
	localparam logic [AW-1:0] START = AW'(lzsswd_pkg::START_PTR);
	localparam logic [AW:0]   FULL  = (AW + 1)'(WINDOW_SIZE);

	logic [AW-1:0] wp_q;
	logic [AW:0]   cnt_q;

	logic       s1_v_q;
	logic       s1_lit_q;
	logic       s1_fwd_q;
	logic       s1_hit_q;
	logic       s1_last_q;
	logic [7:0] s1_byte_q;

	logic       out_v_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	logic [AW-1:0] rd_addr;
	logic [AW-1:0] rd_rel;
	logic [7:0]    rd_data;
	logic [7:0]    s1_val;
	logic          move;
	logic          rd_en;

	// Stage 1 advances into the output register when that register is empty or is read out in the same cycle.
	assign move      = s1_v_q && (!out_v_q || data_ch.ready);
	assign stat.take = !s1_v_q || move;
	assign stat.idle = !s1_v_q;

	// Entries never written since reset or restart read as spaces. Writes run
	// strictly in order from the start pointer, so an entry holds real data
	// exactly when its distance from the start pointer is below the fill count.
	assign rd_addr = AW'(cmd.addr);
	assign rd_rel  = rd_addr - START;
	assign rd_en   = cmd.issue && !cmd.lit;

	// Byte held in stage 1: literal, forwarded write, window data or fill.
	always_comb begin
		if (s1_lit_q || s1_fwd_q) begin
			s1_val = s1_byte_q;
		end else if (s1_hit_q) begin
			s1_val = rd_data;
		end else begin
			s1_val = lzsswd_pkg::FILL_BYTE;
		end
	end

	lzsswd_ram #(
		.WIDTH(8),
		.DEPTH(WINDOW_SIZE)
	) u_hist (
		.clk    (clk),
		.wr_en  (move),
		.wr_addr(wp_q),
		.wr_data(s1_val),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Write pointer and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= START;
			cnt_q <= '0;
		end else if (cmd.restart) begin
			wp_q  <= START;
			cnt_q <= '0;
		end else if (move) begin
			wp_q <= wp_q + AW'(1);
			if (cnt_q != FULL) begin
				cnt_q <= cnt_q + (AW + 1)'(1);
			end
		end
	end

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (cmd.issue) begin
			s1_v_q <= 1'b1;
		end else if (move) begin
			s1_v_q <= 1'b0;
		end
	end

	// Stage 1 payload; a read of the entry written in the same cycle is forwarded.
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			s1_lit_q  <= cmd.lit;
			s1_last_q <= cmd.last;
			s1_fwd_q  <= !cmd.lit && move && (rd_addr == wp_q);
			s1_hit_q  <= {1'b0, rd_rel} < cnt_q;
			s1_byte_q <= cmd.lit ? cmd.lit_byte : s1_val;
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (move) begin
			out_v_q <= 1'b1;
		end else if (data_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (move) begin
			out_byte_q <= s1_val;
			out_last_q <= s1_last_q;
		end
	end

	assign data_ch.valid       = out_v_q;
	assign data_ch.out_byte    = out_byte_q;
	assign data_ch.last_of_run = out_last_q;

	`LZSSWD_ASSERT_NOW(a_issue_has_room, cmd.issue, stat.take, "request issued into an occupied stage")
	`LZSSWD_ASSERT_NOW(a_fill_bounded, 1'b1, cnt_q <= FULL, "fill count beyond window size")
	`LZSSWD_ASSERT_NEXT(a_s1_holds, s1_v_q && !move, s1_v_q && $stable(s1_last_q), "stalled stage 1 lost its byte")

endmodule

`default_nettype wire

// ===== hw/rtl/lzss_window_decompressor.sv =====
// Top level of the LZSS window decompressor: token controller plus window datapath.
// Depends on lzsswd_pkg, lzsswd_if, lzsswd_ctrl and lzsswd_window.
`default_nettype none

// Decodes an LZSS stream given one compressed byte per request on comp_ch and
// returns decoded bytes on data_ch, with last_of_run set on the final byte
// caused by each request. Flag bytes, first pair bytes and restarts give no
// output; a literal gives one byte; a pair gives 3 to 18 bytes copied from
// the 4096-byte history RAM at one byte per cycle while data_ch is not
// stalled, the rate being set by its single read port. A new request is
// taken once the previous copy has been issued and its stage has drained into
// the output register, which may still hold a byte waiting for the consumer.
// The window starts as all spaces with no clearing pass: a fill count tracks
// which entries were written since reset or restart, so restart is immediate.
module lzss_window_decompressor #(
	parameter int unsigned WINDOW_SIZE = 4096
) (
	input wire logic clk,
	input wire logic arst_n,
	lzsswd_in_if.sink comp_ch,
	lzsswd_out_if.source data_ch
);

	lzsswd_pkg::cmd_t  cmd;
	lzsswd_pkg::stat_t stat;

	// Token parsing and copy sequencing.
	lzsswd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.comp_ch(comp_ch),
		.stat   (stat),
		.cmd    (cmd)
	);

	// History window and output stage.
	lzsswd_window #(
		.WINDOW_SIZE(WINDOW_SIZE)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.data_ch(data_ch)
	);

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for lzss_window_decompressor: sends compressed requests and
// predicts every decoded byte from its own copy of the history window.
// Depends on lzsswd_pkg, lzsswd_if and the decompressor RTL.

module tb;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} decoded_t;

	logic clk;
	logic arst_n;

	lzsswd_in_if  comp_ch ();
	lzsswd_out_if data_ch ();

	lzss_window_decompressor dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.comp_ch (comp_ch),
		.data_ch (data_ch)
	);

	// Predicted decoder state.
	logic [7:0]  history_bytes [0:4095];
	logic [11:0] win_ptr;
	logic [15:0] token_bits;
	logic        pair_open;
	logic [7:0]  pair_first;

	decoded_t decoded_due [$];

	bit idle_on;
	int unsigned cycle_count;
	int unsigned mismatches;
	int unsigned requests_sent;
	int unsigned bytes_checked;
	int unsigned restarts_seen;
	int unsigned pairs_seen;

	// Clock.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("lzss_window_decompressor regression: fail");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		mismatches++;
	endtask

	// Window refill and token state clear, as after reset or restart.
	task automatic clear_window();
		foreach (history_bytes[i])
			history_bytes[i] = lzsswd_pkg::FILL_BYTE;
		win_ptr = lzsswd_pkg::START_PTR;
		token_bits = '0;
		pair_open = 1'b0;
		pair_first = '0;
	endtask

	// Writes one decoded byte into the window and queues it for checking.
	task automatic put_byte(input logic [7:0] value, input logic last);
		decoded_t item;
		item.data = value;
		item.last = last;
		history_bytes[win_ptr] = value;
		win_ptr = win_ptr + 12'd1;
		decoded_due.push_back(item);
	endtask

	// Advances the predicted decoder by one accepted request.
	task automatic decode_request(input logic kind, input logic [7:0] data);
		logic [11:0] src;
		int unsigned run_len;
		int unsigned k;
		if (kind == lzsswd_pkg::KIND_RESTART) begin
			clear_window();
			restarts_seen++;
		end else if (!token_bits[8]) begin
			token_bits = {lzsswd_pkg::FLAG_MARK, data};
		end else if (token_bits[0]) begin
			put_byte(data, 1'b1);
			token_bits = token_bits >> 1;
		end else if (!pair_open) begin
			pair_open = 1'b1;
			pair_first = data;
		end else begin
			// Byte-wise copy, so an overlapping run reads bytes it just wrote.
			src = {data[7:4], pair_first};
			run_len = data[3:0] + lzsswd_pkg::MIN_LEN;
			for (k = 0; k < run_len; k++) begin
				put_byte(history_bytes[src], k == run_len - 1);
				src = src + 12'd1;
			end
			pair_open = 1'b0;
			pair_first = '0;
			token_bits = token_bits >> 1;
			pairs_seen++;
		end
	endtask

	// Sends one request, waits for its handshake and updates the prediction.
	task automatic send_request(input logic kind, input logic [7:0] data);
		while (idle_on && $urandom_range(0, 99) < 26) begin
			comp_ch.valid <= 1'b0;
			@(posedge clk);
		end
		comp_ch.valid <= 1'b1;
		comp_ch.kind <= kind;
		comp_ch.in_byte <= data;
		do
			@(posedge clk);
		while (comp_ch.ready !== 1'b1);
		requests_sent++;
		decode_request(kind, data);
	endtask

	task automatic send_copy(input logic [3:0] len_code, input logic [11:0] offset);
		send_request(lzsswd_pkg::KIND_DATA, offset[7:0]);
		send_request(lzsswd_pkg::KIND_DATA, {offset[11:8], len_code});
	endtask

	task automatic send_restart();
		send_request(lzsswd_pkg::KIND_RESTART, 8'($urandom_range(0, 255)));
	endtask

	// Picks a copy source, mostly just behind the write pointer so runs overlap.
	function automatic logic [11:0] pick_offset();
		if ($urandom_range(0, 99) < 60)
			return win_ptr - 12'($urandom_range(1, 20));
		return 12'($urandom_range(0, 4095));
	endfunction

	// One flag byte and its eight tokens; a broken group may stop early or restart.
	task automatic send_token_group(input bit broken);
		logic [7:0] flags;
		int cut;
		int i;
		flags = 8'($urandom_range(0, 255));
		cut = broken ? $urandom_range(0, 8) : 9;
		send_request(lzsswd_pkg::KIND_DATA, flags);
		for (i = 0; i < 8; i++) begin
			if (i == cut) begin
				if ($urandom_range(0, 1))
					send_restart();
				break;
			end
			if (flags[i]) begin
				send_request(lzsswd_pkg::KIND_DATA, 8'($urandom_range(0, 255)));
			end else if (broken && $urandom_range(0, 3) == 0) begin
				// Restart between the two bytes of a pair.
				send_request(lzsswd_pkg::KIND_DATA, 8'($urandom_range(0, 255)));
				send_restart();
				break;
			end else begin
				send_copy(4'($urandom_range(0, 15)), pick_offset());
			end
		end
	endtask

	// Output side: random stalls, and a check of each accepted byte.
	initial begin
		data_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			data_ch.ready <= idle_on ? ($urandom_range(0, 99) >= 26) : 1'b1;
		end
	end

	always @(posedge clk) begin : check_output
		decoded_t want;
		if (arst_n && data_ch.valid === 1'b1 && data_ch.ready === 1'b1) begin
			if (decoded_due.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h", data_ch.out_byte));
			end else begin
				want = decoded_due.pop_front();
				bytes_checked++;
				if (data_ch.out_byte !== want.data)
					report_mismatch($sformatf("out_byte %02h, expected %02h",
						data_ch.out_byte, want.data));
				if (data_ch.last_of_run !== want.last)
					report_mismatch($sformatf("last_of_run %b, expected %b",
						data_ch.last_of_run, want.last));
			end
		end
	end

	// Literal extremes, shortest and longest pairs, overlap, wrap and offset at the pointer.
	task automatic test_literals_and_pairs();
		send_request(lzsswd_pkg::KIND_DATA, 8'h03);
		send_request(lzsswd_pkg::KIND_DATA, 8'h00);
		send_request(lzsswd_pkg::KIND_DATA, 8'hFF);
		send_copy(4'hF, 12'hFF0);
		send_copy(4'h0, 12'h000);
		send_copy(4'h5, 12'hFFF);
		send_copy(4'h2, win_ptr);
		send_copy(4'hA, 12'hA55);
		send_copy(4'h7, 12'h5AA);
	endtask

	// Restart in the middle of a pair must refill the window and reset the pointer.
	task automatic test_restart();
		send_request(lzsswd_pkg::KIND_DATA, 8'h00);
		send_request(lzsswd_pkg::KIND_DATA, 8'h33);
		send_request(lzsswd_pkg::KIND_RESTART, 8'hA5);
		send_request(lzsswd_pkg::KIND_DATA, 8'hFE);
		send_copy(4'hF, lzsswd_pkg::START_PTR);
		send_request(lzsswd_pkg::KIND_DATA, 8'h7E);
		send_request(lzsswd_pkg::KIND_RESTART, 8'h5A);
	endtask

	task automatic test_random_groups(input int unsigned count);
		int unsigned stop_at;
		stop_at = requests_sent + count;
		idle_on = 1'b1;
		while (requests_sent < stop_at)
			send_token_group(1'b0);
	endtask

	// Same traffic with no gaps on the input side and the output always ready.
	task automatic test_back_to_back(input int unsigned count);
		int unsigned stop_at;
		stop_at = requests_sent + count;
		idle_on = 1'b0;
		while (requests_sent < stop_at)
			send_token_group(1'b0);
		idle_on = 1'b1;
	endtask

	// Truncated groups, restarts anywhere and raw byte noise.
	task automatic test_broken_streams(input int unsigned count);
		int unsigned stop_at;
		stop_at = requests_sent + count;
		idle_on = 1'b1;
		while (requests_sent < stop_at) begin
			if ($urandom_range(0, 2) == 0)
				send_request(($urandom_range(0, 9) == 0) ?
					lzsswd_pkg::KIND_RESTART : lzsswd_pkg::KIND_DATA,
					8'($urandom_range(0, 255)));
			else
				send_token_group(1'b1);
		end
	endtask

	task automatic wait_drained();
		comp_ch.valid <= 1'b0;
		while (decoded_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		comp_ch.valid = 1'b0;
		comp_ch.kind = lzsswd_pkg::KIND_DATA;
		comp_ch.in_byte = 8'h00;
		idle_on = 1'b1;
		cycle_count = 0;
		mismatches = 0;
		requests_sent = 0;
		bytes_checked = 0;
		restarts_seen = 0;
		pairs_seen = 0;
		clear_window();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_literals_and_pairs();
		test_restart();
		test_random_groups(260);
		test_back_to_back(110);
		test_broken_streams(90);
		wait_drained();

		$display("covered %0d requests, %0d copy pairs and %0d restarts",
			requests_sent, pairs_seen, restarts_seen);
		$display("checked %0d decoded bytes, %0d mismatches", bytes_checked, mismatches);
		if (mismatches == 0) begin
			$display("lzss_window_decompressor regression: pass");
		end else begin
			$display("lzss_window_decompressor regression: fail");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/lzsswd_pkg.sv
hw/rtl/lzsswd_if.sv
hw/rtl/lzsswd_ram.sv
hw/rtl/lzsswd_ctrl.sv
hw/rtl/lzsswd_window.sv
hw/rtl/lzss_window_decompressor.sv
bench/tb.sv
